### design/thtr_pkg.sv
// Shared types and constants for the thermal head text rasterizer.
`default_nettype none
package thtr_pkg;
   typedef enum logic [2:0] {
      ACT_TEXT  = 3'd0,
      ACT_FONT  = 3'd1,
      ACT_START = 3'd2,
      ACT_TICK  = 3'd3,
      ACT_TEMP  = 3'd4,
      ACT_FAULT = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      KIND_PHASE  = 2'd0,
      KIND_HEAD   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   localparam logic [0:0] CSR_TEMP_LIMIT = 1'b0;
   localparam logic [0:0] CSR_TICKS      = 1'b1;
   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;
   localparam logic [7:0] TEMP_RESET     = 8'd25;
   localparam logic [3:0] TICKS_RESET    = 4'd4;
   localparam int         FONT_GLYPHS    = 96;

   function automatic logic [7:0] phase_bits(input logic [2:0] idx);
      logic [7:0] r;
      begin
         unique case (idx)
            3'd0: r = 8'h0A;
            3'd1: r = 8'h02;
            3'd2: r = 8'h06;
            3'd3: r = 8'h04;
            3'd4: r = 8'h05;
            3'd5: r = 8'h01;
            3'd6: r = 8'h09;
            default: r = 8'h08;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

### design/thtr_text_mem.sv
// Text store: one write port, one registered read port.
`default_nettype none
module thtr_text_mem #(
   parameter int TEXT_DEPTH = 512,
   localparam int AW = $clog2(TEXT_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);
   logic [7:0] mem [TEXT_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### design/thtr_font_mem.sv
// Font store: one write port, one registered read port.
`default_nettype none
module thtr_font_mem #(
   parameter int DEPTH = 6144,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### design/thermal_head_text_rasterizer.sv
// Top level of the thermal head text rasterizer.
//
// Usage:
//   req_ channel: an item (action, font_addr, data) is taken when start is
//   high and busy is low. Text bytes go to the text store (CR ends a message),
//   font writes to the font store, start begins a print, tick steps the motor.
//   rsp_ channel: every result shows for one cycle with rsp_strobe; the
//   receiver cannot stall it. rsp_last marks an item's final result.
//   csr_ channel: valid/ready write of temp_limit (index 0) and ticks_per_row
//   (index 1); ready is high whenever busy and start are both low.
// Timing:
//   Simple items pass through S_STATUS before their registered status result.
//   Start first steps the padded length up one line a cycle (up to the
//   TEXT_DEPTH/LINE_CHARS line cap), then writes one space a cycle (up to a
//   full line of them), then sends the dot row and a phase result; each head
//   byte needs a registered text read (S_RD_TEXT, S_WAIT_TEXT) then a font
//   read (S_RD_FONT, S_WAIT_FONT) before the next begins; a row has 48 bytes.
//   Tick items without a row give their phase result in the cycle after
//   acceptance; with a row the bytes follow, or a status if the text is done.
// Reset: clears control state and registers to their reset values; the text
//   and font stores hold nothing defined until written.
`default_nettype none
module thermal_head_text_rasterizer #(
   parameter int TEXT_DEPTH  = 512,
   parameter int LINE_CHARS  = 24,
   parameter int GLYPH_BYTES = 64,
   parameter int PHASES      = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [12:0] req_font_addr,
   input  wire logic [7:0]  req_data,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_value,
   output logic             rsp_latch,
   output logic             rsp_power,
   output logic             rsp_busy_res,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   localparam int TAW        = $clog2(TEXT_DEPTH);
   localparam int FONT_DEPTH = thtr_pkg::FONT_GLYPHS * GLYPH_BYTES;
   localparam int FAW        = $clog2(FONT_DEPTH);
   localparam int GLYPH_ROWS = GLYPH_BYTES / 2;
   localparam int RW         = $clog2(GLYPH_ROWS) > 0 ? $clog2(GLYPH_ROWS) : 1;
   localparam int CW         = $clog2(LINE_CHARS) > 0 ? $clog2(LINE_CHARS) : 1;
   localparam int CAP_LINES  = TEXT_DEPTH / LINE_CHARS;
   localparam int CAP_LEN    = CAP_LINES * LINE_CHARS;
   localparam int LW         = TAW + 1;
   localparam int PW         = $clog2(PHASES) > 0 ? $clog2(PHASES) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_STATUS, S_LEN, S_PAD, S_RD_TEXT, S_WAIT_TEXT, S_RD_FONT,
      S_WAIT_FONT, S_PHASE0, S_TICK_ROW
   } state_type;

   state_type       state_ff, state_in;
   logic [7:0]      temp_limit_ff;
   logic [3:0]      ticks_ff;
   logic [TAW-1:0]  wr_idx_ff, wr_idx_in;
   logic [LW-1:0]   msg_len_ff, msg_len_in;
   logic [PW-1:0]   phase_ff, phase_in;
   logic [3:0]      tick_cnt_ff, tick_cnt_in;
   logic [RW-1:0]   dot_row_ff, dot_row_in;
   logic [LW-1:0]   line_base_ff, line_base_in;
   logic            running_ff, running_in;
   logic            powered_ff, powered_in;
   logic [LW-1:0]   pad_ptr_ff, pad_ptr_in;
   logic [LW-1:0]   pad_end_ff, pad_end_in;
   logic [CW-1:0]   char_ff, char_in;
   logic            hi_ff, hi_in;
   logic            from_start_ff, from_start_in;
   logic            out_v_ff, out_v_in;
   logic [1:0]      out_kind_ff, out_kind_in;
   logic [7:0]      out_val_ff, out_val_in;
   logic            out_latch_ff, out_latch_in;
   logic            out_last_ff, out_last_in;
   logic            font_ok_ff, font_ok_in;

   logic            t_we;
   logic [TAW-1:0]  t_waddr, t_raddr;
   logic [7:0]      t_wdata, t_rdata;
   logic            f_we;
   logic [FAW-1:0]  f_raddr;
   logic [7:0]      f_rdata;

   logic            accept;
   logic [7:0]      glyph_idx;
   logic [FAW+1:0]  glyph_addr;
   logic [3:0]      tick_next;
   logic [3:0]      ticks_eff;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy && !start;

   assign glyph_idx  = t_rdata - thtr_pkg::CHAR_SPACE;
   assign glyph_addr = (FAW+2)'(glyph_idx) * (FAW+2)'(GLYPH_BYTES)
                       + (FAW+2)'({dot_row_ff, hi_ff});
   assign f_raddr    = glyph_addr[FAW-1:0];
   assign f_we       = accept && (thtr_pkg::action_type'(req_action) == thtr_pkg::ACT_FONT)
                       && ({1'b0, req_font_addr} < 14'(FONT_DEPTH));
   assign t_raddr    = TAW'(line_base_ff + LW'(char_ff));
   assign ticks_eff  = (ticks_ff == 4'd0) ? 4'd1 : ticks_ff;
   assign tick_next  = tick_cnt_ff + 4'd1;

   thtr_text_mem #(.TEXT_DEPTH(TEXT_DEPTH)) u_text (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   thtr_font_mem #(.DEPTH(FONT_DEPTH)) u_font (
      .clock(clock), .we(f_we), .waddr(req_font_addr[FAW-1:0]), .wdata(req_data),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      msg_len_in    = msg_len_ff;
      phase_in      = phase_ff;
      tick_cnt_in   = tick_cnt_ff;
      dot_row_in    = dot_row_ff;
      line_base_in  = line_base_ff;
      running_in    = running_ff;
      powered_in    = powered_ff;
      pad_ptr_in    = pad_ptr_ff;
      pad_end_in    = pad_end_ff;
      char_in       = char_ff;
      hi_in         = hi_ff;
      from_start_in = from_start_ff;
      font_ok_in    = font_ok_ff;
      out_v_in      = 1'b0;
      out_kind_in   = thtr_pkg::KIND_STATUS;
      out_val_in    = 8'd0;
      out_latch_in  = 1'b0;
      out_last_in   = 1'b0;
      t_we          = 1'b0;
      t_waddr       = wr_idx_ff;
      t_wdata       = req_data;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_action)
                  thtr_pkg::ACT_TEXT: begin
                     t_we = 1'b1;
                     if (req_data == thtr_pkg::CHAR_CR) begin
                        msg_len_in = LW'(wr_idx_ff);
                        wr_idx_in  = '0;
                     end else begin
                        wr_idx_in = (32'(wr_idx_ff) == TEXT_DEPTH - 1) ? '0
                                    : wr_idx_ff + TAW'(1);
                     end
                     state_in = S_STATUS;
                  end
                  thtr_pkg::ACT_START: begin
                     if (running_ff) begin
                        state_in = S_STATUS;
                     end else begin
                        wr_idx_in     = '0;
                        dot_row_in    = '0;
                        line_base_in  = '0;
                        running_in    = 1'b1;
                        pad_ptr_in    = msg_len_ff;
                        pad_end_in    = LW'(LINE_CHARS);
                        char_in       = '0;
                        hi_in         = 1'b0;
                        from_start_in = 1'b1;
                        state_in      = S_LEN;
                     end
                  end
                  thtr_pkg::ACT_TICK: begin
                     if (!running_ff) begin
                        state_in = S_STATUS;
                     end else begin
                        out_v_in    = 1'b1;
                        out_kind_in = thtr_pkg::KIND_PHASE;
                        out_val_in  = thtr_pkg::phase_bits(3'(phase_ff));
                        phase_in    = (32'(phase_ff) == PHASES - 1) ? '0
                                      : phase_ff + PW'(1);
                        if (tick_next >= ticks_eff) begin
                           tick_cnt_in = 4'd0;
                           state_in    = S_TICK_ROW;
                        end else begin
                           tick_cnt_in = tick_next;
                           out_last_in = 1'b1;
                        end
                     end
                  end
                  thtr_pkg::ACT_TEMP: begin
                     if (req_data < temp_limit_ff) begin
                        running_in = 1'b0;
                        powered_in = 1'b0;
                     end
                     state_in = S_STATUS;
                  end
                  thtr_pkg::ACT_FAULT: begin
                     running_in = 1'b0;
                     powered_in = 1'b0;
                     state_in   = S_STATUS;
                  end
                  default: state_in = S_STATUS;
               endcase
            end
         end
         S_STATUS: begin
            out_v_in    = 1'b1;
            out_last_in = 1'b1;
            state_in    = S_IDLE;
         end
         S_LEN: begin
            // Advance the padded end a line at a time past the message, up to the cap.
            if (pad_end_ff <= pad_ptr_ff && pad_end_ff < LW'(CAP_LEN)) begin
               pad_end_in = pad_end_ff + LW'(LINE_CHARS);
            end else begin
               msg_len_in = pad_end_ff;
               state_in   = S_PAD;
            end
         end
         S_PAD: begin
            // Write one space a cycle up to the padded end.
            if (pad_ptr_ff < pad_end_ff) begin
               t_we       = 1'b1;
               t_waddr    = TAW'(pad_ptr_ff);
               t_wdata    = thtr_pkg::CHAR_SPACE;
               pad_ptr_in = pad_ptr_ff + LW'(1);
            end else begin
               state_in = S_RD_TEXT;
            end
         end
         S_TICK_ROW: begin
            if (line_base_ff >= msg_len_ff) begin
               running_in   = 1'b0;
               powered_in   = 1'b0;
               dot_row_in   = '0;
               line_base_in = '0;
               phase_in     = '0;
               msg_len_in   = '0;
               state_in     = S_STATUS;
            end else begin
               char_in       = '0;
               hi_in         = 1'b0;
               from_start_in = 1'b0;
               state_in      = S_RD_TEXT;
            end
         end
         S_RD_TEXT: state_in = S_WAIT_TEXT;
         S_WAIT_TEXT: begin
            // Character byte is here; issue the glyph read.
            font_ok_in = (glyph_addr < (FAW+2)'(FONT_DEPTH));
            state_in   = S_RD_FONT;
         end
         S_RD_FONT: state_in = S_WAIT_FONT;
         S_WAIT_FONT: begin
            out_v_in    = 1'b1;
            out_kind_in = thtr_pkg::KIND_HEAD;
            out_val_in  = font_ok_ff ? f_rdata : 8'd0;
            if (!hi_ff) begin
               hi_in    = 1'b1;
               state_in = S_RD_TEXT;
            end else if (32'(char_ff) != LINE_CHARS - 1) begin
               hi_in    = 1'b0;
               char_in  = char_ff + CW'(1);
               state_in = S_RD_TEXT;
            end else begin
               out_latch_in = 1'b1;
               hi_in        = 1'b0;
               char_in      = '0;
               if (32'(dot_row_ff) == GLYPH_ROWS - 1) begin
                  dot_row_in   = '0;
                  line_base_in = line_base_ff + LW'(LINE_CHARS);
               end else begin
                  dot_row_in = dot_row_ff + RW'(1);
               end
               if (from_start_ff) begin
                  state_in = S_PHASE0;
               end else begin
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_PHASE0: begin
            powered_in  = 1'b1;
            out_v_in    = 1'b1;
            out_kind_in = thtr_pkg::KIND_PHASE;
            out_val_in  = thtr_pkg::phase_bits(3'd0);
            out_last_in = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The status fields show the state after the item's changes up to that
   // result; power rises with the phase result after a start.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         temp_limit_ff <= thtr_pkg::TEMP_RESET;
         ticks_ff      <= thtr_pkg::TICKS_RESET;
         wr_idx_ff     <= '0;
         msg_len_ff    <= '0;
         phase_ff      <= '0;
         tick_cnt_ff   <= '0;
         dot_row_ff    <= '0;
         line_base_ff  <= '0;
         running_ff    <= 1'b0;
         powered_ff    <= 1'b0;
         out_v_ff      <= 1'b0;
         rsp_power     <= 1'b0;
         rsp_busy_res  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         msg_len_ff   <= msg_len_in;
         phase_ff     <= phase_in;
         tick_cnt_ff  <= tick_cnt_in;
         dot_row_ff   <= dot_row_in;
         line_base_ff <= line_base_in;
         running_ff   <= running_in;
         powered_ff   <= powered_in;
         out_v_ff     <= out_v_in;
         rsp_power    <= (state_ff == S_PHASE0) ? 1'b1 : powered_in;
         rsp_busy_res <= running_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               thtr_pkg::CSR_TEMP_LIMIT: temp_limit_ff <= csr_wdata;
               thtr_pkg::CSR_TICKS:      ticks_ff      <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pad_ptr_ff    <= pad_ptr_in;
      pad_end_ff    <= pad_end_in;
      char_ff       <= char_in;
      hi_ff         <= hi_in;
      from_start_ff <= from_start_in;
      font_ok_ff    <= font_ok_in;
      out_kind_ff   <= out_kind_in;
      out_val_ff    <= out_val_in;
      out_latch_ff  <= out_latch_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_value  = out_val_ff;
   assign rsp_latch  = out_latch_ff;
   assign rsp_last   = out_last_ff;
endmodule
`default_nettype wire

### design/thtr_checker.sv
// Port-level checks for the thermal head text rasterizer.
`default_nettype none
module thtr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [1:0] rsp_kind,
   input wire logic       rsp_latch,
   input wire logic       rsp_last,
   input wire logic       csr_ready
);
   a_latch_head: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_latch |-> rsp_kind == thtr_pkg::KIND_HEAD)
      else $error("latch on non-head result");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted item neither raised busy nor gave a result");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after last result");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("csr ready while busy");
endmodule

bind thermal_head_text_rasterizer thtr_checker u_thtr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_latch(rsp_latch),
   .rsp_last(rsp_last), .csr_ready(csr_ready)
);
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the thermal head text rasterizer.
`timescale 1ns / 1ps
module tb_top;
   localparam int TEXT_DEPTH  = 512;
   localparam int LINE_CHARS  = 24;
   localparam int GLYPH_BYTES = 64;
   localparam int PHASES      = 8;
   localparam int FONT_DEPTH  = thtr_pkg::FONT_GLYPHS * GLYPH_BYTES;
   localparam int GLYPH_ROWS  = GLYPH_BYTES / 2;
   localparam int STALL_LIMIT = 20000;
   // spare action codes the block answers with a bare status
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]  action;
      logic [12:0] faddr;
      logic [7:0]  data;
   } print_item_type;

   typedef struct packed {
      thtr_pkg::kind_type kind;
      logic [7:0]         value;
      logic               latch;
      logic               power;
      logic               busy_res;
      logic               last;
   } head_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [12:0] req_font_addr = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_value;
   logic        rsp_latch, rsp_power, rsp_busy_res, rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   thermal_head_text_rasterizer u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_font_addr(req_font_addr), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_value(rsp_value),
      .rsp_latch(rsp_latch), .rsp_power(rsp_power), .rsp_busy_res(rsp_busy_res),
      .rsp_last(rsp_last), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Printer mirror: text and font stores, print position, registers.
   // ---------------------------------------------------------------------
   logic [7:0] text_mem [TEXT_DEPTH];
   logic [7:0] font_mem [FONT_DEPTH];
   int unsigned wr_idx = 0, msg_len = 0, ph_idx = 0, tick_cnt = 0;
   int unsigned row = 0, base = 0;
   bit          printing = 0, powered = 0;
   int unsigned hot_limit = thtr_pkg::TEMP_RESET;
   int unsigned row_ticks = thtr_pkg::TICKS_RESET;

   head_out_type   head_expected[$];
   print_item_type pending_items[$];

   int unsigned n_queued = 0, n_accepted = 0, n_results = 0, n_rows = 0;
   int unsigned n_stops = 0, errors = 0, stall_cycles = 0;
   bit          quiet = 0;
   int unsigned gap = 0;

   // which font bytes the stimulus has written, to keep glyph reads defined
   bit font_written [FONT_DEPTH];

   function automatic void expect_out(thtr_pkg::kind_type k, logic [7:0] v, logic l);
      head_expected.push_back('{k, v, l, powered, printing, 1'b0});
   endfunction

   function automatic logic [7:0] glyph_byte(logic [7:0] c, int unsigned b);
      int unsigned addr;
      addr = int'(8'(c - thtr_pkg::CHAR_SPACE)) * GLYPH_BYTES + b;
      return (addr < FONT_DEPTH) ? font_mem[addr] : 8'd0;
   endfunction

   // Send the current dot row of the current text line, then advance.
   function automatic void predict_row();
      logic [7:0]  c;
      int unsigned b;
      for (int p = 0; p < LINE_CHARS; p++) begin
         c = text_mem[(base + p) % TEXT_DEPTH];
         b = (row % GLYPH_ROWS) * 2;
         expect_out(thtr_pkg::KIND_HEAD, glyph_byte(c, b), 1'b0);
         expect_out(thtr_pkg::KIND_HEAD, glyph_byte(c, b + 1), p == LINE_CHARS - 1);
      end
      n_rows++;
      row++;
      if (row >= GLYPH_ROWS) begin
         row = 0;
         base += LINE_CHARS;
      end
   endfunction

   function automatic void predict_print(print_item_type it);
      int unsigned lines, padded;
      case (it.action)
         thtr_pkg::ACT_TEXT: begin
            wr_idx = wr_idx % TEXT_DEPTH;
            text_mem[wr_idx] = it.data;
            if (it.data == thtr_pkg::CHAR_CR) begin
               msg_len = wr_idx;
               wr_idx = 0;
            end else begin
               wr_idx = (wr_idx + 1) % TEXT_DEPTH;
            end
            expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
         end
         thtr_pkg::ACT_FONT: begin
            if (it.faddr < FONT_DEPTH) font_mem[it.faddr] = it.data;
            expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
         end
         thtr_pkg::ACT_START: begin
            if (printing) begin
               expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
            end else begin
               wr_idx = 0;
               row = 0;
               base = 0;
               printing = 1;
               // pad to whole lines, an exact multiple gains a blank line
               lines = msg_len / LINE_CHARS + 1;
               if (lines > TEXT_DEPTH / LINE_CHARS) lines = TEXT_DEPTH / LINE_CHARS;
               padded = lines * LINE_CHARS;
               for (int unsigned j = msg_len; j < padded; j++)
                  text_mem[j % TEXT_DEPTH] = thtr_pkg::CHAR_SPACE;
               msg_len = padded;
               predict_row();
               powered = 1;
               expect_out(thtr_pkg::KIND_PHASE, thtr_pkg::phase_bits(3'd0), 1'b0);
            end
         end
         thtr_pkg::ACT_TICK: begin
            if (!printing) begin
               expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
            end else begin
               expect_out(thtr_pkg::KIND_PHASE,
                          thtr_pkg::phase_bits(3'(ph_idx % PHASES)), 1'b0);
               ph_idx = (ph_idx + 1) % PHASES;
               tick_cnt = (tick_cnt + 1) & 4'hF;
               if (tick_cnt >= row_ticks) begin
                  tick_cnt = 0;
                  if (base >= msg_len) begin
                     // text exhausted: power down and clear position
                     printing = 0;
                     powered = 0;
                     row = 0;
                     base = 0;
                     ph_idx = 0;
                     msg_len = 0;
                     n_stops++;
                     expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
                  end else begin
                     predict_row();
                  end
               end
            end
         end
         thtr_pkg::ACT_TEMP: begin
            if (it.data < hot_limit) begin
               printing = 0;
               powered = 0;
            end
            expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
         end
         thtr_pkg::ACT_FAULT: begin
            printing = 0;
            powered = 0;
            expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
         end
         default: expect_out(thtr_pkg::KIND_STATUS, 8'd0, 1'b0);
      endcase
      head_expected[head_expected.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued items, with random bursts of idle cycles.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      print_item_type it;
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
      end else if (!(start && busy)) begin
         // the item on the ports (if any) was just taken
         if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            start <= 1'b1;
            req_action <= it.action;
            req_font_addr <= it.faddr;
            req_data <= it.data;
            if (!quiet && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 13);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on acceptance, check every strobed result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      head_out_type got, want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (start && !busy) begin
            predict_print(print_item_type'{req_action, req_font_addr, req_data});
            n_accepted++;
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         if (rsp_strobe) begin
            moved = 1'b1;
            n_results++;
            got = '{thtr_pkg::kind_type'(rsp_kind), rsp_value, rsp_latch, rsp_power,
                    rsp_busy_res, rsp_last};
            if (head_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind=%0d value=%02h latch=%0b power=%0b busy=%0b last=%0b",
                        $time, rsp_kind, rsp_value, rsp_latch, rsp_power, rsp_busy_res, rsp_last);
            end else begin
               want = head_expected.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected kind=%0d value=%02h latch=%0b power=%0b busy=%0b last=%0b",
                           $time, want.kind, want.value, want.latch, want.power,
                           want.busy_res, want.last);
                  $display("%0t:          actual   kind=%0d value=%02h latch=%0b power=%0b busy=%0b last=%0b",
                           $time, rsp_kind, rsp_value, rsp_latch, rsp_power,
                           rsp_busy_res, rsp_last);
               end
            end
         end
         stall_cycles <= moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_item(logic [2:0] a, logic [12:0] f, logic [7:0] d);
      if (a == thtr_pkg::ACT_FONT && f < FONT_DEPTH) font_written[f] = 1;
      pending_items.push_back(print_item_type'{a, f, d});
      n_queued++;
   endtask

   function automatic bit glyph_ready(logic [7:0] c);
      int unsigned g;
      g = int'(8'(c - thtr_pkg::CHAR_SPACE));
      if (g >= thtr_pkg::FONT_GLYPHS) return 1;   // outside the store: prints blank
      for (int b = 0; b < GLYPH_BYTES; b++)
         if (!font_written[g * GLYPH_BYTES + b]) return 0;
      return 1;
   endfunction

   // Pick a printable character whose glyph never reads an unwritten byte.
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0, 1, 2: c = thtr_pkg::CHAR_SPACE;
         3: c = 8'd65;
         4: c = 8'd127;
         5: c = 8'($urandom_range(128, 255));
         6: c = 8'($urandom_range(14, 31));
         default: c = 8'($urandom_range(0, 255));
      endcase
      if (c == thtr_pkg::CHAR_CR || !glyph_ready(c)) c = thtr_pkg::CHAR_SPACE;
      return c;
   endfunction

   task automatic load_glyph(logic [7:0] c);
      for (int b = 0; b < GLYPH_BYTES; b++)
         queue_item(thtr_pkg::ACT_FONT,
                    13'(int'(8'(c - thtr_pkg::CHAR_SPACE)) * GLYPH_BYTES + b),
                    8'($urandom_range(0, 255)));
   endtask

   task automatic queue_message(int unsigned len);
      for (int unsigned i = 0; i < len; i++) queue_item(thtr_pkg::ACT_TEXT, '0, pick_char());
      queue_item(thtr_pkg::ACT_TEXT, 13'($urandom_range(0, 8191)), thtr_pkg::CHAR_CR);
   endtask

   // A well-formed print job with random content and some noise mixed in.
   task automatic queue_job();
      int unsigned len, ticks;
      case ($urandom_range(0, 5))
         0: len = LINE_CHARS;
         1: len = 0;
         default: len = $urandom_range(1, 20);
      endcase
      queue_message(len);
      queue_item(thtr_pkg::ACT_START, 13'($urandom_range(0, 8191)),
                 8'($urandom_range(0, 255)));
      ticks = $urandom_range(8, 20);
      for (int unsigned t = 0; t < ticks; t++) begin
         case ($urandom_range(0, 19))
            0: queue_item(thtr_pkg::ACT_TEXT, '0, pick_char());
            1: queue_item(thtr_pkg::ACT_FONT, 13'($urandom_range(0, 8191)),
                          8'($urandom_range(0, 255)));
            2: queue_item(thtr_pkg::ACT_TEMP, '0, 8'($urandom_range(0, 255)));
            3: queue_item($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, '0, '0);
            4: queue_item(thtr_pkg::ACT_START, '0, '0);
            default: queue_item(thtr_pkg::ACT_TICK, 13'($urandom_range(0, 8191)),
                                8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 2) == 0) queue_item(thtr_pkg::ACT_FAULT, '0, '0);
   endtask

   // Hold until every queued item is taken and every result has come.
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (n_accepted != n_queued || head_expected.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == thtr_pkg::CSR_TEMP_LIMIT) hot_limit = val;
      else row_ticks = val & 8'h0F;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   logic [7:0] limits [5] = '{8'd0, 8'd255, 8'd25, 8'd100, 8'd10};
   logic [7:0] tickset [5] = '{8'd1, 8'd15, 8'd0, 8'hF3, 8'd2};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // glyph for space; codes outside the store print blank without one
      load_glyph(thtr_pkg::CHAR_SPACE);

      // directed: odd characters, repeated start, stops, spares, ignored writes
      queue_item(thtr_pkg::ACT_TEXT, '0, thtr_pkg::CHAR_SPACE);
      queue_item(thtr_pkg::ACT_TEXT, '0, 8'd150);
      queue_item(thtr_pkg::ACT_TEXT, '0, 8'd200);
      queue_item(thtr_pkg::ACT_TEXT, '0, 8'd5);
      queue_item(thtr_pkg::ACT_TEXT, '0, 8'd255);
      queue_item(thtr_pkg::ACT_TEXT, '0, 8'd0);
      queue_item(thtr_pkg::ACT_TEXT, '0, thtr_pkg::CHAR_CR);
      queue_item(thtr_pkg::ACT_START, '0, '0);
      queue_item(thtr_pkg::ACT_START, 13'h1FFF, 8'hFF);
      repeat (5) queue_item(thtr_pkg::ACT_TICK, '0, '0);
      queue_item(thtr_pkg::ACT_TEMP, '0, 8'd255);
      queue_item(thtr_pkg::ACT_TICK, '0, '0);
      queue_item(thtr_pkg::ACT_TEMP, '0, 8'd0);
      queue_item(thtr_pkg::ACT_TICK, '0, '0);
      queue_item(thtr_pkg::ACT_FAULT, '0, '0);
      queue_item(ACT_SPARE_A, '0, '0);
      queue_item(ACT_SPARE_B, '0, '0);
      queue_item(thtr_pkg::ACT_FONT, 13'h1FFF, 8'hFF);
      queue_item(thtr_pkg::ACT_FONT, 13'(FONT_DEPTH), 8'h00);
      queue_item(thtr_pkg::ACT_TEXT, '0, thtr_pkg::CHAR_CR);
      queue_item(thtr_pkg::ACT_START, '0, '0);
      queue_item(thtr_pkg::ACT_FAULT, '0, '0);
      drain();

      // random jobs under several register settings, last one without idling
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(thtr_pkg::CSR_TEMP_LIMIT, limits[ph]);
         write_csr(thtr_pkg::CSR_TICKS, tickset[ph]);
         quiet = (ph == 4);
         queue_job();
         drain();
      end

      $display("Covered %0d items and %0d results: %0d dot rows, %0d end-of-text stops.",
               n_accepted, n_results, n_rows, n_stops);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

### thermal_head_text_rasterizer.f
design/thtr_pkg.sv
design/thtr_text_mem.sv
design/thtr_font_mem.sv
design/thermal_head_text_rasterizer.sv
design/thtr_checker.sv
verif/tb_top.sv
